// ----- rtl/clbp_pkg.sv -----
// Shared types, constants and sine/cosine tables for the circular LBP core.
// No dependencies; every other file but clbp_ram refers to it by scoped names.

package clbp_pkg;

    // Default frame store geometry.
    localparam int unsigned MAX_WIDTH_DEF  = 128;
    localparam int unsigned MAX_HEIGHT_DEF = 128;

    // Configuration port geometry.
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 8;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_THRESHOLD_A    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_NEIGHBOR_COUNT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RADIUS         = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT   = 3'd4;

    // Configuration reset values.
    localparam logic [3:0] THRESHOLD_A_RST    = 4'd3;
    localparam logic [3:0] NEIGHBOR_COUNT_RST = 4'd6;
    localparam logic [3:0] RADIUS_RST         = 4'd2;
    localparam logic [7:0] FRAME_WIDTH_RST    = 8'd128;
    localparam logic [7:0] FRAME_HEIGHT_RST   = 8'd128;

    // Neighbour count limits.
    localparam logic [3:0] NCOUNT_MIN = 4'd3;
    localparam logic [3:0] NCOUNT_MAX = 4'd8;

    // Operation codes carried in the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Circle offsets, 8 fraction bits, one row per neighbour count from 3 to 8.
    localparam logic signed [9:0] COS_ROM [0:5][0:7] = '{
        '{10'sd256, -10'sd128, -10'sd128, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
        '{10'sd256, 10'sd0, -10'sd256, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
        '{10'sd256, 10'sd79, -10'sd207, -10'sd207, 10'sd79, 10'sd0, 10'sd0, 10'sd0},
        '{10'sd256, 10'sd128, -10'sd128, -10'sd256, -10'sd128, 10'sd128, 10'sd0,
          10'sd0},
        '{10'sd256, 10'sd160, -10'sd57, -10'sd231, -10'sd231, -10'sd57, 10'sd160,
          10'sd0},
        '{10'sd256, 10'sd181, 10'sd0, -10'sd181, -10'sd256, -10'sd181, 10'sd0,
          10'sd181}
    };

    localparam logic signed [9:0] SIN_ROM [0:5][0:7] = '{
        '{10'sd0, 10'sd222, -10'sd222, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
        '{10'sd0, 10'sd256, 10'sd0, -10'sd256, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
        '{10'sd0, 10'sd243, 10'sd150, -10'sd150, -10'sd243, 10'sd0, 10'sd0, 10'sd0},
        '{10'sd0, 10'sd222, 10'sd222, 10'sd0, -10'sd222, -10'sd222, 10'sd0, 10'sd0},
        '{10'sd0, 10'sd200, 10'sd250, 10'sd111, -10'sd111, -10'sd250, -10'sd200,
          10'sd0},
        '{10'sd0, 10'sd181, 10'sd256, 10'sd181, 10'sd0, -10'sd181, -10'sd256,
          -10'sd181}
    };

    // Which pixel a frame store read fetches.
    typedef enum logic [2:0] {
        RD_CENTRE,
        RD_P00,
        RD_P01,
        RD_P10,
        RD_P11
    } rd_kind_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_COORD,
        ST_RD00,
        ST_RD01,
        ST_RD10,
        ST_RD11,
        ST_DRAIN,
        ST_MIX0,
        ST_MIX1,
        ST_CMP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     wr_pixel;
        logic     load_query;
        logic     start;
        logic     coord_load;
        logic     rd_en;
        rd_kind_t rd_kind;
        logic     mix0;
        logic     mix1;
        logic     shift_bit;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_neighbour;
        logic out_busy;
    } status_t;

endpackage

// ----- rtl/clbp_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; used for the frame store.

module clbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: a write, or a read whose data appears next cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/clbp_datapath.sv -----
// Datapath of the circular LBP core: configuration registers, frame store,
// sample coordinates, bilinear mixing and the output register. Uses clbp_pkg
// and clbp_ram.

module clbp_datapath #(
    parameter int unsigned MAX_WIDTH  = clbp_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = clbp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [clbp_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [clbp_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic [6:0]                  in_col,
    input  logic [6:0]                  in_row,
    input  logic [7:0]                  in_gray,
    input  clbp_pkg::cmd_t              cmd,
    output clbp_pkg::status_t           status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata
);

    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SXW   = XW + 11;
    localparam int unsigned SYW   = YW + 11;

    // Configuration registers.
    logic [3:0] thr_reg;
    logic [3:0] ncount_reg;
    logic [3:0] radius_reg;
    logic [7:0] fwidth_reg;
    logic [7:0] fheight_reg;

    // Query and sample state.
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [XW-1:0] fx_reg, fx_next;
    logic [YW-1:0] fy_reg, fy_next;
    logic [7:0]    ax_reg, ax_next;
    logic [7:0]    ay_reg, ay_next;
    logic [7:0]    centre_reg, centre_next;
    logic [15:0]   top_reg, top_next;
    logic [15:0]   bot_reg, bot_next;
    logic [23:0]   acc_reg, acc_next;
    logic [7:0]    code_reg, code_next;
    logic [2:0]    k_reg, k_next;
    logic          cap_valid_reg;
    clbp_pkg::rd_kind_t cap_kind_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;

    // Effective configuration.
    logic [3:0]    p_eff;
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;
    logic [2:0]    rom_idx;

    // Coordinate arithmetic.
    logic signed [9:0]     cos_v, sin_v;
    logic signed [14:0]    off_x, off_y;
    logic signed [SXW-1:0] xs, lim_x;
    logic signed [SYW-1:0] ys, lim_y;
    logic [XW+7:0]         xc;
    logic [YW+7:0]         yc;
    logic [XW-1:0]         cx;
    logic [YW-1:0]         cy;

    // Frame store access.
    logic [XW-1:0] rd_x;
    logic [YW-1:0] rd_y;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;

    // Shared multiplier.
    logic [8:0]  mul_a;
    logic [15:0] mul_b;
    logic [24:0] prod;
    logic [8:0]  wx_lo, wy_lo;
    logic [7:0]  g;
    logic        code_bit;

    // Configuration writes; indexes outside the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= clbp_pkg::THRESHOLD_A_RST;
            ncount_reg  <= clbp_pkg::NEIGHBOR_COUNT_RST;
            radius_reg  <= clbp_pkg::RADIUS_RST;
            fwidth_reg  <= clbp_pkg::FRAME_WIDTH_RST;
            fheight_reg <= clbp_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                clbp_pkg::CFG_THRESHOLD_A:    thr_reg     <= cfg_wdata[3:0];
                clbp_pkg::CFG_NEIGHBOR_COUNT: ncount_reg  <= cfg_wdata[3:0];
                clbp_pkg::CFG_RADIUS:         radius_reg  <= cfg_wdata[3:0];
                clbp_pkg::CFG_FRAME_WIDTH:    fwidth_reg  <= cfg_wdata[7:0];
                clbp_pkg::CFG_FRAME_HEIGHT:   fheight_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Saturated neighbour count and last column and row of the frame.
    always_comb begin
        if (ncount_reg < clbp_pkg::NCOUNT_MIN) begin
            p_eff = clbp_pkg::NCOUNT_MIN;
        end else if (ncount_reg > clbp_pkg::NCOUNT_MAX) begin
            p_eff = clbp_pkg::NCOUNT_MAX;
        end else begin
            p_eff = ncount_reg;
        end
        rom_idx = 3'(p_eff - clbp_pkg::NCOUNT_MIN);

        if (fwidth_reg == 8'd0) begin
            wm1 = '0;
        end else if (int'(fwidth_reg) > int'(MAX_WIDTH)) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(fwidth_reg - 8'd1);
        end

        if (fheight_reg == 8'd0) begin
            hm1 = '0;
        end else if (int'(fheight_reg) > int'(MAX_HEIGHT)) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(fheight_reg - 8'd1);
        end
    end

    // Sample point for neighbour k, clamped to the frame.
    always_comb begin
        cos_v = clbp_pkg::COS_ROM[rom_idx][k_reg];
        sin_v = clbp_pkg::SIN_ROM[rom_idx][k_reg];
        off_x = $signed({1'b0, radius_reg}) * cos_v;
        off_y = $signed({1'b0, radius_reg}) * sin_v;
        xs    = $signed({3'b000, col_reg, 8'h00}) + SXW'(off_x);
        ys    = $signed({3'b000, row_reg, 8'h00}) + SYW'(off_y);
        lim_x = $signed({3'b000, wm1, 8'h00});
        lim_y = $signed({3'b000, hm1, 8'h00});

        if (xs[SXW-1]) begin
            xc = '0;
        end else if (xs > lim_x) begin
            xc = {wm1, 8'h00};
        end else begin
            xc = xs[XW+7:0];
        end

        if (ys[SYW-1]) begin
            yc = '0;
        end else if (ys > lim_y) begin
            yc = {hm1, 8'h00};
        end else begin
            yc = ys[YW+7:0];
        end

        cx = fx_reg + {{(XW-1){1'b0}}, |ax_reg};
        cy = fy_reg + {{(YW-1){1'b0}}, |ay_reg};
    end

    // Frame store address: a write from the input beat or one of the reads.
    always_comb begin
        case (cmd.rd_kind)
            clbp_pkg::RD_CENTRE: begin
                rd_x = col_reg;
                rd_y = row_reg;
            end
            clbp_pkg::RD_P00: begin
                rd_x = fx_reg;
                rd_y = fy_reg;
            end
            clbp_pkg::RD_P01: begin
                rd_x = cx;
                rd_y = fy_reg;
            end
            clbp_pkg::RD_P10: begin
                rd_x = fx_reg;
                rd_y = cy;
            end
            clbp_pkg::RD_P11: begin
                rd_x = cx;
                rd_y = cy;
            end
            default: begin
                rd_x = col_reg;
                rd_y = row_reg;
            end
        endcase

        ram_we = cmd.wr_pixel && (int'(in_col) < int'(MAX_WIDTH))
                 && (int'(in_row) < int'(MAX_HEIGHT));
        if (cmd.wr_pixel) begin
            ram_addr = AW'(int'(in_row) * int'(MAX_WIDTH) + int'(in_col));
        end else begin
            ram_addr = AW'(int'(rd_y) * int'(MAX_WIDTH) + int'(rd_x));
        end
    end

    clbp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_gray),
        .rdata (ram_rdata)
    );

    // Shared multiplier: read weights while data returns, row weights when mixing.
    always_comb begin
        wx_lo = 9'd256 - {1'b0, ax_reg};
        wy_lo = 9'd256 - {1'b0, ay_reg};
        mul_a = '0;
        mul_b = '0;
        if (cap_valid_reg) begin
            mul_b = {8'h00, ram_rdata};
            case (cap_kind_reg)
                clbp_pkg::RD_P00: mul_a = wx_lo;
                clbp_pkg::RD_P10: mul_a = wx_lo;
                clbp_pkg::RD_P01: mul_a = {1'b0, ax_reg};
                clbp_pkg::RD_P11: mul_a = {1'b0, ax_reg};
                default:          mul_a = '0;
            endcase
        end else if (cmd.mix0) begin
            mul_a = wy_lo;
            mul_b = top_reg;
        end else if (cmd.mix1) begin
            mul_a = {1'b0, ay_reg};
            mul_b = bot_reg;
        end
        prod = mul_a * mul_b;
    end

    // Comparison of the interpolated value with the centre pixel.
    always_comb begin
        g        = acc_reg[23:16];
        code_bit = ({1'b0, g} + {5'b00000, thr_reg}) >= {1'b0, centre_reg};
    end

    // Next-state logic for the datapath registers.
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        centre_next   = centre_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        acc_next      = acc_reg;
        code_next     = code_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        // Query position, clamped to the frame in use.
        if (cmd.load_query) begin
            col_next = (int'(in_col) > int'(wm1)) ? wm1 : XW'(in_col);
            row_next = (int'(in_row) > int'(hm1)) ? hm1 : YW'(in_row);
        end

        if (cmd.start) begin
            code_next = '0;
            k_next    = '0;
        end

        if (cmd.coord_load) begin
            fx_next = xc[XW+7:8];
            ax_next = xc[7:0];
            fy_next = yc[YW+7:8];
            ay_next = yc[7:0];
        end

        // Read data returning from the frame store.
        if (cap_valid_reg) begin
            case (cap_kind_reg)
                clbp_pkg::RD_CENTRE: centre_next = ram_rdata;
                clbp_pkg::RD_P00:    top_next    = prod[15:0];
                clbp_pkg::RD_P01:    top_next    = top_reg + prod[15:0];
                clbp_pkg::RD_P10:    bot_next    = prod[15:0];
                clbp_pkg::RD_P11:    bot_next    = bot_reg + prod[15:0];
                default: ;
            endcase
        end

        if (cmd.mix0) begin
            acc_next = prod[23:0];
        end
        if (cmd.mix1) begin
            acc_next = acc_reg + prod[23:0];
        end

        if (cmd.shift_bit) begin
            code_next = {code_reg[6:0], code_bit};
            k_next    = k_reg + 3'd1;
        end

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = code_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_valid_reg <= 1'b0;
            cap_kind_reg  <= clbp_pkg::RD_CENTRE;
            m_tvalid_reg  <= 1'b0;
            k_reg         <= '0;
        end else begin
            cap_valid_reg <= cmd.rd_en;
            cap_kind_reg  <= cmd.rd_kind;
            m_tvalid_reg  <= m_tvalid_next;
            k_reg         <= k_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        centre_reg  <= centre_next;
        top_reg     <= top_next;
        bot_reg     <= bot_next;
        acc_reg     <= acc_next;
        code_reg    <= code_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign status.last_neighbour = ({1'b0, k_reg} == (p_eff - 4'd1));
    assign status.out_busy       = m_tvalid_reg && !m_tready;
    assign m_tvalid              = m_tvalid_reg;
    assign m_tdata               = m_tdata_reg;

endmodule

// ----- rtl/clbp_ctrl.sv -----
// Controller of the circular LBP core: takes pixel writes, sequences the centre
// read and, for each neighbour, coordinates, four frame reads, mixing and comparison, then the output. Uses clbp_pkg.

module clbp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              op,
    input  clbp_pkg::status_t status,
    output clbp_pkg::cmd_t    cmd
);

    clbp_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.rd_kind = clbp_pkg::RD_CENTRE;

        case (state_reg)
            clbp_pkg::ST_IDLE: begin
                // No beat is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    if (op == clbp_pkg::OP_WRITE) begin
                        cmd.wr_pixel = 1'b1;
                    end else begin
                        cmd.load_query = 1'b1;
                        state_next     = clbp_pkg::ST_CENTRE;
                    end
                end
            end
            clbp_pkg::ST_CENTRE: begin
                cmd.start   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = clbp_pkg::RD_CENTRE;
                state_next  = clbp_pkg::ST_COORD;
            end
            clbp_pkg::ST_COORD: begin
                cmd.coord_load = 1'b1;
                state_next     = clbp_pkg::ST_RD00;
            end
            clbp_pkg::ST_RD00: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = clbp_pkg::RD_P00;
                state_next  = clbp_pkg::ST_RD01;
            end
            clbp_pkg::ST_RD01: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = clbp_pkg::RD_P01;
                state_next  = clbp_pkg::ST_RD10;
            end
            clbp_pkg::ST_RD10: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = clbp_pkg::RD_P10;
                state_next  = clbp_pkg::ST_RD11;
            end
            clbp_pkg::ST_RD11: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = clbp_pkg::RD_P11;
                state_next  = clbp_pkg::ST_DRAIN;
            end
            clbp_pkg::ST_DRAIN: begin
                state_next = clbp_pkg::ST_MIX0;
            end
            clbp_pkg::ST_MIX0: begin
                cmd.mix0   = 1'b1;
                state_next = clbp_pkg::ST_MIX1;
            end
            clbp_pkg::ST_MIX1: begin
                cmd.mix1   = 1'b1;
                state_next = clbp_pkg::ST_CMP;
            end
            clbp_pkg::ST_CMP: begin
                cmd.shift_bit = 1'b1;
                if (status.last_neighbour) begin
                    state_next = clbp_pkg::ST_DONE;
                end else begin
                    state_next = clbp_pkg::ST_COORD;
                end
            end
            clbp_pkg::ST_DONE: begin
                // Wait until the output register has room for the code.
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = clbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = clbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/circular_lbp_code_core.sv -----
// Circular local binary pattern core over a stored gray frame.
//
// Input channel s_*: each beat is a pixel write (s_tuser low) or a pattern
// query (s_tuser high) at a column and row. Result channel m_*: one 8-bit
// code per query, first neighbour in the most significant used bit.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// do so only while the core is idle, which the core does not enforce.
//
// A write gives no result and keeps the core idle. A query occupies the
// core: one centre read (ST_CENTRE), then per neighbour a coordinate step
// (ST_COORD), four reads of the single-port frame store (ST_RD00-ST_RD11),
// a step for the last read data (ST_DRAIN), mixing (ST_MIX0, ST_MIX1) and
// comparison (ST_CMP); ST_DONE then loads the code into the output register.
//
// Reset restores the configuration defaults and empties the output register;
// the frame store is not cleared and holds garbage until written. The output
// register frees the input side while a code waits; a second query finishes
// its work and then waits until the receiver takes the earlier code.
// Depends on clbp_pkg, clbp_ctrl, clbp_datapath and clbp_ram.

module circular_lbp_code_core #(
    parameter int unsigned MAX_WIDTH  = clbp_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = clbp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic [clbp_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [clbp_pkg::CFG_DW-1:0] cfg_wdata,
    // Input channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // col[6:0], row[13:7], gray[21:14], zero
    input  logic                        s_tuser,  // op[0]
    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata   // code[7:0]
);

    clbp_pkg::cmd_t    cmd;
    clbp_pkg::status_t status;

    // Sequencer.
    clbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // Frame store and arithmetic.
    clbp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_col    (s_tdata[6:0]),
        .in_row    (s_tdata[13:7]),
        .in_gray   (s_tdata[21:14]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
